FILE: rtl/core/ngat_pkg.sv
// ----------------------------------------------------------------------------
// ngat_pkg
// Shared constants and types of the node acceleration gather core.
// ----------------------------------------------------------------------------
package ngat_pkg;

   // default data format, signed q16.32 in a 48-bit word
   localparam int unsigned DATA_WIDTH_DEF = 48;
   localparam int unsigned FRAC_BITS_DEF  = 32;

   // configuration port
   localparam int unsigned CSR_DATA_WIDTH = 64;
   localparam int unsigned CSR_ADDR_WIDTH = 4;

   // register select, taken from the byte address bit 3
   localparam logic CSR_IDX_DENSITY_CUT = 1'b0;
   localparam logic CSR_IDX_ZERO_CUT    = 1'b1;

   // register reset values
   localparam logic [63:0] DENSITY_CUT_RESET = 64'd4295;
   localparam logic [63:0] ZERO_CUT_RESET    = 64'd1;

   // status of a shared iterative unit
   typedef struct packed {
      logic busy;
      logic done;
   } ngat_unit_sts_type;

endpackage

FILE: rtl/core/node_acceleration_gather_core.sv
// ----------------------------------------------------------------------------
// node_acceleration_gather_core
// Gathers corner mass, area and force of a mesh node and returns its
// acceleration and mass on the node's last corner word.
// ----------------------------------------------------------------------------
// A corner word whose corner mass or preceding corner mass passes the zero
// cut takes that mass as its weight; otherwise the weight falls back to
// density times area (one pass of the shift-add multiplier, DATA_WIDTH-1
// steps between its start and its done strobe).
// A last-corner word adds one more multiplier pass for the density cut test
// and, when the mass passes, two passes of the restoring divider of
// DATA_WIDTH+FRAC_BITS steps each; a floored last word takes no divider pass.
// req_tready is high only while no word is in work; a finished result waits
// in the output register and the next word is taken meanwhile, so a stalled
// result only holds the core once the next node result is ready.
module node_acceleration_gather_core
   import ngat_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
   localparam int unsigned REQ_TDATA_W = ((6 * DATA_WIDTH - 4 + 7) / 8) * 8,
   localparam int unsigned RSP_TDATA_W = ((3 * DATA_WIDTH - 1 + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // request stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // corner_mass, prev_corner_mass, corner_area, element_density, force_x, force_y
   input  logic [REQ_TDATA_W-1:0]     req_tdata,
   // has_contribution
   input  logic                       req_tuser,
   // last_corner
   input  logic                       req_tlast,
   // response stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // accel_x, accel_y, node_mass
   output logic [RSP_TDATA_W-1:0]     rsp_tdata,
   // mass_floored
   output logic                       rsp_tuser,
   // configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned W  = DATA_WIDTH;
   localparam int unsigned UW = DATA_WIDTH - 1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_WEIGHT = 9'b000000010,
      ST_WMUL   = 9'b000000100,
      ST_ACCUM  = 9'b000001000,
      ST_TSTART = 9'b000010000,
      ST_TMUL   = 9'b000100000,
      ST_DIVX   = 9'b001000000,
      ST_DIVY   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;

   logic [UW-1:0]             dcut_ff, zcut_ff;
   logic                      csr_wr;

   logic [UW-1:0]             cm_ff, pm_ff, ca_ff, ed_ff;
   logic signed [W-1:0]       fx_ff, fy_ff;
   logic                      has_ff, last_ff;
   logic [UW-1:0]             w_ff, w_in;

   logic [UW-1:0]             mass_sum_ff, mass_sum_in;
   logic [UW-1:0]             area_sum_ff, area_sum_in;
   logic signed [W-1:0]       fx_sum_ff, fx_sum_in;
   logic signed [W-1:0]       fy_sum_ff, fy_sum_in;

   logic signed [W-1:0]       ax_ff, ax_in;
   logic signed [W-1:0]       ay_ff, ay_in;
   logic [UW-1:0]             mass_ff, mass_in;
   logic                      floored_ff, floored_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                      rsp_flag_ff, rsp_flag_in;

   logic                      mul_start;
   logic [UW-1:0]             mul_a, mul_b, mul_res;
   ngat_unit_sts_type         mul_sts;
   logic                      div_start;
   logic signed [W-1:0]       div_num, div_quot;
   ngat_unit_sts_type         div_sts;

   logic [UW:0]               mass_add, area_add;
   logic signed [W-1:0]       fx_add, fy_add;
   logic                      fx_ovf, fy_ovf;
   logic                      req_acc, rsp_free;

   // configuration registers
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dcut_ff <= DENSITY_CUT_RESET[UW-1:0];
         zcut_ff <= ZERO_CUT_RESET[UW-1:0];
      end else if (csr_wr) begin
         case (csr_paddr[3])
            CSR_IDX_DENSITY_CUT: dcut_ff <= csr_pwdata[UW-1:0];
            CSR_IDX_ZERO_CUT:    zcut_ff <= csr_pwdata[UW-1:0];
            default:             dcut_ff <= dcut_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3])
         CSR_IDX_DENSITY_CUT: csr_prdata = {{(CSR_DATA_WIDTH-UW){1'b0}}, dcut_ff};
         CSR_IDX_ZERO_CUT:    csr_prdata = {{(CSR_DATA_WIDTH-UW){1'b0}}, zcut_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // shared arithmetic units
   assign mul_start = ((state_ff == ST_WEIGHT) && has_ff && !(cm_ff > zcut_ff)
                       && !(pm_ff > zcut_ff)) || (state_ff == ST_TSTART);
   assign mul_a     = (state_ff == ST_TSTART) ? dcut_ff : ed_ff;
   assign mul_b     = (state_ff == ST_TSTART) ? area_sum_ff : ca_ff;

   ngat_qmul #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_qmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .sts    (mul_sts),
      .result (mul_res)
   );

   assign div_start = ((state_ff == ST_TMUL) && mul_sts.done && (mass_sum_ff > mul_res))
                      || ((state_ff == ST_DIVX) && div_sts.done);
   assign div_num   = (state_ff == ST_TMUL) ? fx_sum_ff : fy_sum_ff;

   ngat_qdiv #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_qdiv (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_num),
      .denom  (mass_sum_ff),
      .sts    (div_sts),
      .quot   (div_quot)
   );

   // saturating accumulators
   assign mass_add = {1'b0, mass_sum_ff} + {1'b0, w_ff};
   assign area_add = {1'b0, area_sum_ff} + {1'b0, ca_ff};
   assign fx_add   = fx_sum_ff + fx_ff;
   assign fy_add   = fy_sum_ff + fy_ff;
   assign fx_ovf   = (fx_sum_ff[W-1] == fx_ff[W-1]) && (fx_add[W-1] != fx_ff[W-1]);
   assign fy_ovf   = (fy_sum_ff[W-1] == fy_ff[W-1]) && (fy_add[W-1] != fy_ff[W-1]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      mass_sum_in  = mass_sum_ff;
      area_sum_in  = area_sum_ff;
      fx_sum_in    = fx_sum_ff;
      fy_sum_in    = fy_sum_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      mass_in      = mass_ff;
      floored_in   = floored_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            if (!has_ff) begin
               state_in = last_ff ? ST_TSTART : ST_IDLE;
            end else if (cm_ff > zcut_ff) begin
               w_in     = cm_ff;
               state_in = ST_ACCUM;
            end else if (pm_ff > zcut_ff) begin
               w_in     = pm_ff;
               state_in = ST_ACCUM;
            end else begin
               state_in = ST_WMUL;
            end
         end
         ST_WMUL: begin
            if (mul_sts.done) begin
               w_in     = mul_res;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            mass_sum_in = mass_add[UW] ? {UW{1'b1}} : mass_add[UW-1:0];
            area_sum_in = area_add[UW] ? {UW{1'b1}} : area_add[UW-1:0];
            fx_sum_in   = fx_ovf ? {fx_ff[W-1], {(W-1){!fx_ff[W-1]}}} : fx_add;
            fy_sum_in   = fy_ovf ? {fy_ff[W-1], {(W-1){!fy_ff[W-1]}}} : fy_add;
            state_in    = last_ff ? ST_TSTART : ST_IDLE;
         end
         ST_TSTART: begin
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            if (mul_sts.done) begin
               if (mass_sum_ff > mul_res) begin
                  floored_in = 1'b0;
                  mass_in    = mass_sum_ff;
                  state_in   = ST_DIVX;
               end else begin
                  floored_in = 1'b1;
                  mass_in    = (zcut_ff > mul_res) ? zcut_ff : mul_res;
                  ax_in      = '0;
                  ay_in      = '0;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_DIVX: begin
            if (div_sts.done) begin
               ax_in    = div_quot;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_sts.done) begin
               ay_in    = div_quot;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand the result to the output register and clear the node sums
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({mass_ff, ay_ff, ax_ff});
               rsp_flag_in  = floored_ff;
               mass_sum_in  = '0;
               area_sum_in  = '0;
               fx_sum_in    = '0;
               fy_sum_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cm_ff   <= req_tdata[UW-1:0];
         pm_ff   <= req_tdata[2*UW-1:UW];
         ca_ff   <= req_tdata[3*UW-1:2*UW];
         ed_ff   <= req_tdata[4*UW-1:3*UW];
         fx_ff   <= req_tdata[4*UW+W-1:4*UW];
         fy_ff   <= req_tdata[4*UW+2*W-1:4*UW+W];
         has_ff  <= req_tuser;
         last_ff <= req_tlast;
      end
      w_ff        <= w_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      mass_ff     <= mass_in;
      floored_ff  <= floored_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         mass_sum_ff  <= '0;
         area_sum_ff  <= '0;
         fx_sum_ff    <= '0;
         fy_sum_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mass_sum_ff  <= mass_sum_in;
         area_sum_ff  <= area_sum_in;
         fx_sum_ff    <= fx_sum_in;
         fy_sum_ff    <= fy_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // multiplier finishes only while the sequencer waits on it
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == ST_WMUL || state_ff == ST_TMUL))
      else $error("multiplier done outside a multiply wait");

   // divider finishes only while the sequencer waits on it
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DIVX || state_ff == ST_DIVY))
      else $error("divider done outside a divide wait");

   // a floored result carries zero acceleration
   a_floored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[2*W-1:0] == '0))
      else $error("floored result with nonzero acceleration");

   // sums are clear after a result has been issued
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (mass_sum_ff == '0 && area_sum_ff == '0))
      else $error("node sums not cleared after result");

endmodule

FILE: rtl/core/ngat_qmul.sv
// ----------------------------------------------------------------------------
// ngat_qmul
// Iterative shift-add fixed-point multiplier, one multiplier bit per cycle.
// Result is the product with the fraction bits dropped, saturated.
// ----------------------------------------------------------------------------
module ngat_qmul
   import ngat_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DATA_WIDTH-2:0]   op_a,
   input  logic [DATA_WIDTH-2:0]   op_b,
   output ngat_unit_sts_type       sts,
   output logic [DATA_WIDTH-2:0]   result
);

   localparam int unsigned UW = DATA_WIDTH - 1;
   localparam int unsigned PW = 2 * UW;
   localparam int unsigned CW = $clog2(DATA_WIDTH);
   localparam logic [CW-1:0] LAST_STEP = CW'(UW - 1);

   logic [PW-1:0]          acc_ff, acc_in;
   logic [UW-1:0]          a_ff, a_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [UW:0]            part_sum;
   logic [PW+UW:0]         prod_ext;
   logic [PW+UW:0]         prod_shr;
   logic                   sat;

   // one add of the multiplicand into the upper half, then shift right
   assign part_sum = {1'b0, acc_ff[PW-1:UW]} + (acc_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {{UW{1'b0}}, op_b};
         a_in    = op_a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {part_sum, acc_ff[UW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // drop the fraction bits and saturate at the largest magnitude
   assign prod_ext = {{(UW+1){1'b0}}, acc_ff};
   assign prod_shr = prod_ext >> FRAC_BITS;
   assign sat      = |prod_shr[PW+UW:UW];
   assign result   = sat ? {UW{1'b1}} : prod_shr[UW-1:0];

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

FILE: rtl/core/ngat_qdiv.sv
// ----------------------------------------------------------------------------
// ngat_qdiv
// Restoring fixed-point divider, one quotient bit per cycle.
// Signed numerator over positive denominator, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module ngat_qdiv
   import ngat_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [DATA_WIDTH-1:0]   numer,
   input  logic [DATA_WIDTH-2:0]          denom,
   output ngat_unit_sts_type              sts,
   output logic signed [DATA_WIDTH-1:0]   quot
);

   localparam int unsigned W  = DATA_WIDTH;
   localparam int unsigned NW = DATA_WIDTH + FRAC_BITS;
   localparam int unsigned CW = $clog2(NW);
   localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);
   localparam logic [NW-1:0] POS_LIM = {{(FRAC_BITS+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NW-1:0] NEG_LIM = POS_LIM + 1'b1;

   logic [NW-1:0]    dvd_ff, dvd_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [W-2:0]     rem_ff, rem_in;
   logic [W-2:0]     den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W-1:0]     mag;
   logic [W-1:0]     trial;
   logic [W-1:0]     diff;
   logic             ge;
   logic             sat;

   assign mag   = numer[W-1] ? (~numer + 1'b1) : numer;
   assign trial = {rem_ff, dvd_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = {mag, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         den_in  = denom;
         neg_in  = numer[W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // bring down one dividend bit, subtract if it fits
         dvd_in = {dvd_ff[NW-2:0], 1'b0};
         rem_in = ge ? diff[W-2:0] : trial[W-2:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // saturate to the signed range, then apply the sign
   assign sat = neg_ff ? (quo_ff > NEG_LIM) : (quo_ff > POS_LIM);

   always_comb begin
      if (neg_ff) begin
         quot = sat ? {1'b1, {(W-1){1'b0}}} : (~quo_ff[W-1:0] + 1'b1);
      end else begin
         quot = sat ? {1'b0, {(W-1){1'b1}}} : quo_ff[W-1:0];
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
